FILE: sv/bttk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bttk_pkg
// Shared types and constants of the bounded top-k sorted set unit.
// ----------------------------------------------------------------------------
package bttk_pkg;

  // field widths
  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int CAP_BITS     = 7;
  localparam int COUNT_BITS   = 7;

  // storage depth default and capacity register reset value
  localparam int          DEF_CAPACITY  = 64;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

  // offered pair, also the form of one stored entry
  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  // result of one offered pair
  typedef struct packed {
    logic                  accepted;
    logic                  evicted;
    logic [KEY_BITS-1:0]   evicted_key;
    logic [VALUE_BITS-1:0] evicted_value;
    logic [COUNT_BITS-1:0] count;
  } out_item_t;

  // control broadcast to every cell
  typedef struct packed {
    logic cmp;    // capture compare flags against the offered pair
    logic grow;   // insert, shifting larger entries up one cell
    logic evict;  // insert, shifting smaller entries down and dropping cell 0
  } cell_ctl_t;

endpackage

FILE: sv/bttk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bttk_cell
// One slot of the sorted chain: holds an entry, compares it with the offered
// pair and takes the pair or a neighbor's entry on an insert.
// ----------------------------------------------------------------------------
module bttk_cell
  import bttk_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  in_item_t  pair,
  input  logic      occ,
  input  in_item_t  left_entry,
  input  logic      left_ltc,
  input  in_item_t  right_entry,
  input  logic      right_ltc,
  output in_item_t  entry,
  output logic      ltc,
  output logic      eq
);

  in_item_t entry_r, entry_nxt;
  logic     ltc_r, eq_r;
  logic     lt_now, eq_now;

  // pair order: key first, then value
  always_comb begin
    eq_now = (entry_r.key == pair.key) && (entry_r.value == pair.value);
    lt_now = (entry_r.key < pair.key) ||
             ((entry_r.key == pair.key) && (entry_r.value < pair.value));
  end

  // next entry on an insert; grow and evict never come together
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.grow) begin
      if (!ltc_r) begin
        entry_nxt = left_ltc ? pair : left_entry;
      end
    end else if (ctl.evict) begin
      if (right_ltc) begin
        entry_nxt = right_entry;
      end else if (ltc_r) begin
        entry_nxt = pair;
      end
    end
  end

  // entry storage and compare flags
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp) begin
      ltc_r <= occ & lt_now;
      eq_r  <= occ & eq_now;
    end
  end

  assign entry = entry_r;
  assign ltc   = ltc_r;
  assign eq    = eq_r;

endmodule

FILE: sv/bounded_top_k_sorted_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_top_k_sorted_set_unit
// Keeps the largest distinct (key, value) pairs in a sorted chain of cells,
// evicting the minimum once the configured capacity is reached.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid / in_stall  in_item  (key, value)
//   out_     out  out_valid/ out_stall out_item (accepted, evicted, pair, count)
//   cfg_     in   cfg_valid/ cfg_ready cfg_data (capacity)
//
// each item passes in turn through accept, compare in every cell, update of the chain
// the update waits while the output register still holds an untaken item
// a new item is accepted while the previous result waits in the output register
// rst_n is synchronous; it empties the set and sets capacity to 64
// no clearing pass: cells beyond the held count are masked out of every compare
// ----------------------------------------------------------------------------
module bounded_top_k_sorted_set_unit
  import bttk_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data
);

  localparam int HW = $clog2(CAPACITY + 1);
  localparam int WW = (HW > CAP_BITS) ? HW : CAP_BITS;

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_UPD} state_t;

  state_t              state_r;
  in_item_t            pair_r;
  logic [HW-1:0]       held_r;
  logic [HW-1:0]       held_nxt;
  logic [CAP_BITS-1:0] cap_r;
  logic                out_valid_r;
  out_item_t           out_item_r;

  cell_ctl_t           ctl;
  in_item_t            entries [CAPACITY];
  logic [CAPACITY-1:0] ltc_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] occ_v;

  logic [WW-1:0]       cap_eff;
  logic [WW-1:0]       held_w;
  logic                full, dup, can_out, grow_go, evict_go;

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // effective capacity and fullness
  always_comb begin
    held_w = WW'(held_r);
    if (cap_r == '0) begin
      cap_eff = WW'(1);
    end else if (WW'(cap_r) > WW'(CAPACITY)) begin
      cap_eff = WW'(CAPACITY);
    end else begin
      cap_eff = WW'(cap_r);
    end
    full = (held_w >= cap_eff);
  end

  // insert decision from the registered cell flags
  always_comb begin
    dup      = |eq_v;
    can_out  = !out_valid_r || !out_stall;
    grow_go  = (state_r == S_UPD) && can_out && !full && !dup;
    evict_go = (state_r == S_UPD) && can_out && full && ltc_v[0] && !dup;
    ctl.cmp   = (state_r == S_CMP);
    ctl.grow  = grow_go;
    ctl.evict = evict_go;
    held_nxt  = held_r + HW'(grow_go);
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    in_item_t left_e, right_e;
    logic     left_l, right_l;

    assign occ_v[i] = (held_r > HW'(i));

    if (i == 0) begin : g_first
      assign left_e = pair_r;
      assign left_l = 1'b1;
    end else begin : g_mid_l
      assign left_e = entries[i-1];
      assign left_l = ltc_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entries[i];
      assign right_l = 1'b0;
    end else begin : g_mid_r
      assign right_e = entries[i+1];
      assign right_l = ltc_v[i+1];
    end

    bttk_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .pair        (pair_r),
      .occ         (occ_v[i]),
      .left_entry  (left_e),
      .left_ltc    (left_l),
      .right_entry (right_e),
      .right_ltc   (right_l),
      .entry       (entries[i]),
      .ltc         (ltc_v[i]),
      .eq          (eq_v[i])
    );
  end

  // sequencer, count, capacity and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // output valid: set by a finished update, cleared when taken
      if ((state_r == S_UPD) && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            pair_r  <= in_item;
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (can_out) begin
            held_r                   <= held_nxt;
            out_item_r.accepted      <= grow_go | evict_go;
            out_item_r.evicted       <= evict_go;
            out_item_r.evicted_key   <= evict_go ? entries[0].key : '0;
            out_item_r.evicted_value <= evict_go ? entries[0].value : '0;
            out_item_r.count         <= COUNT_BITS'(WW'(held_nxt));
            state_r                  <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the set never holds more than the storage depth
  assert property (@(posedge clk) disable iff (!rst_n) held_r <= HW'(CAPACITY))
    else $error("held count above storage depth");

  // an insert either grows the set or evicts, never both
  assert property (@(posedge clk) disable iff (!rst_n) !(ctl.grow && ctl.evict))
    else $error("grow and evict together");

  // an eviction leaves the count unchanged
  assert property (@(posedge clk) disable iff (!rst_n) ctl.evict |=> $stable(held_r))
    else $error("count changed on eviction");

  // a reported eviction always comes with an accepted item
  assert property (@(posedge clk) disable iff (!rst_n)
                   out_valid_r && out_item_r.evicted |-> out_item_r.accepted)
    else $error("eviction without acceptance");
`endif

endmodule

FILE: tb/sv/top_k_set_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_set_checker
// Watches the pair, result and capacity channels of the top-k set unit. It
// keeps its own sorted copy of the held pairs, works out the result of every
// accepted pair and compares each delivered result field by field.
// ----------------------------------------------------------------------------
module top_k_set_checker
  import bttk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  in_item_t            in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  out_item_t           out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CAP_BITS-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending_results,
  output int                  inserted_total,
  output int                  evicted_total
);

  localparam int DEPTH     = DEF_CAPACITY;
  localparam int PAIR_BITS = KEY_BITS + VALUE_BITS;

  // sorted held pairs, index 0 is the smallest; key sits in the upper bits,
  // so a plain unsigned compare orders by key first and then by value
  logic [PAIR_BITS-1:0] held_pairs [DEPTH];
  int                   held_total;
  logic [CAP_BITS-1:0]  cap_setting;

  out_item_t            expected_results [$];
  out_item_t            want;
  int                   reported;

  function automatic int effective_limit(input logic [CAP_BITS-1:0] c);
    if (c == '0) return 1;
    if (int'(c) > DEPTH) return DEPTH;
    return int'(c);
  endfunction

  // offer one pair to the held set, returning the result it produces
  function automatic out_item_t offer_pair(input in_item_t p);
    logic [PAIR_BITS-1:0] pv;
    out_item_t            r;
    int                   lim;
    int                   pos;
    pv  = p;
    r   = '0;
    lim = effective_limit(cap_setting);
    pos = 0;
    while (pos < held_total && held_pairs[pos] < pv) pos++;
    if (pos < held_total && held_pairs[pos] == pv) begin
      // already held: rejected
    end else if (held_total >= lim) begin
      // full: only a pair above the minimum gets in, the minimum drops out
      if (pv > held_pairs[0]) begin
        r.accepted = 1'b1;
        r.evicted  = 1'b1;
        {r.evicted_key, r.evicted_value} = held_pairs[0];
        for (int i = 0; i + 1 < pos; i++) held_pairs[i] = held_pairs[i+1];
        held_pairs[pos-1] = pv;
      end
    end else begin
      // room left: shift larger pairs up and insert
      r.accepted = 1'b1;
      for (int i = held_total; i > pos; i--) held_pairs[i] = held_pairs[i-1];
      held_pairs[pos] = pv;
      held_total++;
    end
    r.count = COUNT_BITS'(held_total);
    return r;
  endfunction

  assign pending_results = expected_results.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      held_total     = 0;
      cap_setting    = CAP_RESET;
      fail_count     = 0;
      reported       = 0;
      inserted_total = 0;
      evicted_total  = 0;
      expected_results.delete();
    end else begin
      // capacity writes
      if (cfg_valid && cfg_ready) cap_setting = cfg_data;

      // accepted pair: predict its result
      if (in_valid && !in_stall) begin
        want = offer_pair(in_item);
        expected_results.insert(expected_results.size(), want);
        if (want.accepted) inserted_total++;
        if (want.evicted) evicted_total++;
      end

      // delivered result: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (reported < 10) begin
            $display("%0t: result with no pair outstanding: acc=%0b ev=%0b %h/%h cnt=%0d",
                     $time, out_item.accepted, out_item.evicted, out_item.evicted_key,
                     out_item.evicted_value, out_item.count);
            reported++;
          end
        end else begin
          want = expected_results.pop_front();
          if (out_item.accepted !== want.accepted || out_item.evicted !== want.evicted ||
              out_item.evicted_key !== want.evicted_key ||
              out_item.evicted_value !== want.evicted_value ||
              out_item.count !== want.count) begin
            fail_count++;
            if (reported < 10) begin
              $display("%0t: mismatch exp acc=%0b ev=%0b %h/%h cnt=%0d",
                       $time, want.accepted, want.evicted, want.evicted_key,
                       want.evicted_value, want.count);
              $display("%0t:          got acc=%0b ev=%0b %h/%h cnt=%0d",
                       $time, out_item.accepted, out_item.evicted,
                       out_item.evicted_key, out_item.evicted_value, out_item.count);
              reported++;
            end
          end
        end
      end
    end
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the bounded top-k sorted set unit: a directed pass over the
// edge cases (duplicates, ties on key, pairs at and below the minimum,
// capacity zero, above the store depth and below the held count), then
// random pairs across several capacity settings with random gaps and stalls
// on both sides. The checker beside the block does the predicting.
// ----------------------------------------------------------------------------
module tb_top;
  import bttk_pkg::*;

  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 8;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_stall;
  out_item_t           out_item;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_BITS-1:0] cfg_data;

  int                  fail_count;
  int                  pending_results;
  int                  inserted_total;
  int                  evicted_total;

  bit                  no_gaps;
  int                  hold_reqs;
  int                  holds_done;
  int                  pairs_offered;
  int                  cap_writes;
  in_item_t            recent_pairs [$];

  logic [CAP_BITS-1:0] phase_caps [PHASES] =
    '{7'd64, 7'd5, 7'd127, 7'd1, 7'd0, 7'd33, 7'd65, 7'd100, 7'd12, 7'd64};

  bounded_top_k_sorted_set_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  top_k_set_checker set_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item        (out_item),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .inserted_total  (inserted_total),
    .evicted_total   (evicted_total)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // result side: random stalls, one long hold on request
  initial begin
    out_stall  = 1'b0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_stall = 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else begin
        out_stall = !no_gaps && rst_n && ($urandom_range(99) < 32);
      end
    end
  end

  // offer one pair, holding it until taken; called and returns at a falling edge
  task automatic send_pair(input logic [KEY_BITS-1:0] k, input logic [VALUE_BITS-1:0] v);
    in_item_t p;
    p.key   = k;
    p.value = v;
    while (!no_gaps && $urandom_range(99) < 32) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = p;
    do @(posedge clk); while (in_stall);
    pairs_offered++;
    recent_pairs.insert(recent_pairs.size(), p);
    if (recent_pairs.size() > 64) void'(recent_pairs.pop_front());
    @(negedge clk);
  endtask

  // stop offering until every predicted result has been delivered
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_BITS-1:0] c);
    drain_results();
    cfg_valid = 1'b1;
    cfg_data  = c;
    do @(posedge clk); while (!cfg_ready);
    cap_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random pair: high-band keys with ties, repeats and near repeats of
  // recent pairs, plus low and extreme pairs and fully random ones
  function automatic in_item_t pick_pair();
    in_item_t p;
    int       sel;
    sel     = $urandom_range(99);
    p.key   = $urandom;
    p.value = $urandom;
    if (sel < 25) begin
      p.key = {24'hFFFFFF, 8'($urandom_range(255))};
      if ($urandom_range(1)) p.value = $urandom_range(15);
    end else if (sel < 45 && recent_pairs.size() > 0) begin
      p = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
    end else if (sel < 55 && recent_pairs.size() > 0) begin
      p = recent_pairs[$urandom_range(recent_pairs.size() - 1)];
      p.value = $urandom_range(1) ? p.value + 1 : p.value - 1;
    end else if (sel < 70) begin
      p.key   = $urandom_range(3);
      p.value = $urandom_range(3);
    end else if (sel < 80) begin
      p.key   = $urandom_range(1) ? '1 : '0;
      p.value = $urandom_range(1) ? '1 : '0;
    end
    return p;
  endfunction

  initial begin
    in_item_t rp;
    in_valid      = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    no_gaps       = 1'b0;
    hold_reqs     = 0;
    pairs_offered = 0;
    cap_writes    = 0;
    rst_n         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // capacity two from empty: duplicates, fill, minimum and below
    write_capacity(7'd2);
    send_pair(32'h0, 32'h0);
    send_pair(32'h0, 32'h0);
    send_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pair(32'h0, 32'h0);
    send_pair(32'h1, 32'h0);
    send_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_pair(32'h0, 32'hFFFFFFFF);

    // above the store depth: grows again, ties on key ordered by value
    write_capacity(7'd127);
    send_pair(32'h5, 32'h7);
    send_pair(32'h5, 32'h3);
    send_pair(32'h5, 32'hFFFFFFFF);
    send_pair(32'h5, 32'h7);
    send_pair(32'hFFFFFFFF, 32'h0);
    send_pair(32'h0, 32'h0);
    send_pair(32'hAAAAAAAA, 32'h55555555);
    send_pair(32'h55555555, 32'hAAAAAAAA);

    // capacity zero, below the held count: replace the minimum only
    write_capacity(7'd0);
    send_pair(32'h0, 32'h0);
    send_pair(32'h0, 32'h1);
    send_pair(32'h5, 32'h3);
    send_pair(32'hFFFFFFFF, 32'hFFFFFFFE);
    send_pair(32'h0, 32'h1);

    // random phases
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      no_gaps = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) hold_reqs++;
        if (ph == 5 && n == 60) drain_results();
        rp = pick_pair();
        send_pair(rp.key, rp.value);
      end
    end
    no_gaps = 1'b0;

    drain_results();
    $display("summary: %0d pairs over %0d capacity writes, %0d inserted, %0d evictions",
             pairs_offered, cap_writes, inserted_total, evicted_total);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: bounded_top_k_sorted_set_unit.f
sv/bttk_pkg.sv
sv/bttk_cell.sv
sv/bounded_top_k_sorted_set_unit.sv
tb/sv/top_k_set_checker.sv
tb/sv/tb_top.sv
